FILE: design/mjc_pkg.sv
package mjc_pkg;

	localparam int IN_FRAC_BITS = 16;
	localparam int IN_W  = 32;
	localparam int T_W   = 24;
	localparam int C_W   = 64;
	localparam int DIV_BITS = 64;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	localparam int DIF_W  = IN_W + 1;
	localparam int VT_W   = IN_W + T_W + 1;
	localparam int T2_W   = 2 * T_W;
	localparam int T3_W   = 3 * T_W;
	localparam int T4_W   = 4 * T_W;
	localparam int T5_W   = 5 * T_W;
	localparam int ATT_W  = VT_W + T_W + 1;
	localparam int B1_W   = imax(DIF_W + IN_FRAC_BITS, VT_W) + 1;
	localparam int B1T_W  = B1_W + T_W + 1;
	localparam int B2T_W  = DIF_W + T_W + 1;
	localparam int B2TT_W = B2T_W + T_W + 1;
	localparam int B0_W   = imax(imax(DIF_W + 2 * IN_FRAC_BITS + 1, VT_W + IN_FRAC_BITS + 1),
		ATT_W) + 2;
	localparam int N_W    = imax(imax(B0_W, B1T_W), B2TT_W) + 6;
	localparam int DEN_W  = T5_W + 1;
	localparam int SH3    = 31;
	localparam int SH4    = IN_FRAC_BITS + 31;
	localparam int SH5    = 2 * IN_FRAC_BITS + 31;
	localparam int XW     = imax(N_W + SH5 + 2, DEN_W + DIV_BITS);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int LAT     = 6 + 1 + DIV_BITS;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZERO_T = 2'd1;
	localparam logic [1:0] ST_SAT    = 2'd2;

	localparam logic signed [C_W-1:0] COEF_MAX = {1'b0, {(C_W-1){1'b1}}};
	localparam logic signed [C_W-1:0] COEF_MIN = {1'b1, {(C_W-1){1'b0}}};

	typedef logic signed [IN_W-1:0]   in_t;
	typedef logic [T_W-1:0]           t_t;
	typedef logic signed [DIF_W-1:0]  dif_t;
	typedef logic signed [VT_W-1:0]   vt_t;
	typedef logic [T2_W-1:0]          t2_t;
	typedef logic [T3_W-1:0]          t3_t;
	typedef logic [T4_W-1:0]          t4_t;
	typedef logic [T5_W-1:0]          t5_t;
	typedef logic signed [ATT_W-1:0]  att_t;
	typedef logic signed [B1_W-1:0]   b1_t;
	typedef logic signed [B1T_W-1:0]  b1t_t;
	typedef logic signed [B2T_W-1:0]  b2t_t;
	typedef logic signed [B2TT_W-1:0] b2tt_t;
	typedef logic signed [B0_W-1:0]   b0_t;
	typedef logic signed [N_W-1:0]    n_t;
	typedef logic [N_W-1:0]           mag_t;
	typedef logic [XW-1:0]            num_t;
	typedef logic [DEN_W-1:0]         den_t;
	typedef logic signed [C_W-1:0]    coef_t;

	typedef struct packed {
		logic zero;
		in_t  p0;
		in_t  v0;
		in_t  a0;
		t_t   t;
		dif_t dp;
		dif_t dv;
		dif_t b2;
	} entry_t;

	typedef struct packed {
		num_t num;
		den_t den;
		logic neg;
	} div_in_t;

	typedef struct packed {
		logic [DIV_BITS-1:0] q;
		logic                ovf;
		logic                neg;
	} div_out_t;

endpackage

FILE: design/mjc_if.sv
interface mjc_req_if import mjc_pkg::*; ();
	logic valid;
	logic ready;
	in_t  start_pos;
	in_t  start_vel;
	in_t  start_acc;
	in_t  end_pos;
	in_t  end_vel;
	in_t  end_acc;
	t_t   duration;

	modport source(output valid, start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
		duration, input ready);
	modport sink(input valid, start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
		duration, output ready);
endinterface

interface mjc_rsp_if import mjc_pkg::*; ();
	logic       valid;
	logic       ready;
	coef_t      coef0;
	coef_t      coef1;
	coef_t      coef2;
	coef_t      coef3;
	coef_t      coef4;
	coef_t      coef5;
	logic [1:0] status;

	modport source(output valid, coef0, coef1, coef2, coef3, coef4, coef5, status, input ready);
	modport sink(input valid, coef0, coef1, coef2, coef3, coef4, coef5, status, output ready);
endinterface

FILE: design/min_jerk_coefficients_core.sv
// Minimum-jerk quintic coefficient engine.
// req: one beat per manoeuvre, start and end position, velocity, acceleration
//   (signed Q16.16) and duration T (unsigned Q8.16).
// rsp: one beat per req beat, in order: coef0..coef5 (signed Q32.32) and status
//   (0 ok, 1 zero duration with all coefficients zero, 2 a coefficient clamped).
// Throughput: one beat per cycle while rsp is not stalled. A six-stage multiply/residual
//   pipe feeds three restoring dividers (one quotient bit per stage, 64 quotient bits),
//   which feed the output register.
// A four-entry queue sits between the input side and the arithmetic pipe, so req
//   keeps being accepted while the queue has room.
// When rsp is stalled the whole arithmetic pipe holds; the output register keeps
//   its beat until taken, meanwhile the queue fills and req.ready drops.
// Reset empties the queue and clears all valid flags; nothing is kept between
//   beats.
module min_jerk_coefficients_core import mjc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mjc_req_if.sink   req,
	mjc_rsp_if.source rsp
);

	logic   push, full, pop, nempty;
	entry_t wentry, hentry;

	mjc_front u_front (
		.req   (req),
		.full  (full),
		.push  (push),
		.entry (wentry)
	);

	mjc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.full   (full),
		.pop    (pop),
		.rdata  (hentry),
		.nempty (nempty)
	);

	mjc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (hentry),
		.head_valid (nempty),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

FILE: design/mjc_front.sv
module mjc_front import mjc_pkg::*; (
	mjc_req_if.sink req,
	input  logic    full,
	output logic    push,
	output entry_t  entry
);

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		entry.zero = (req.duration == '0);
		entry.p0   = req.start_pos;
		entry.v0   = req.start_vel;
		entry.a0   = req.start_acc;
		entry.t    = req.duration;
		entry.dp   = dif_t'(req.end_pos) - dif_t'(req.start_pos);
		entry.dv   = dif_t'(req.end_vel) - dif_t'(req.start_vel);
		entry.b2   = dif_t'(req.end_acc) - dif_t'(req.start_acc);
	end

endmodule

FILE: design/mjc_queue.sv
module mjc_queue import mjc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	output logic   full,
	input  logic   pop,
	output entry_t rdata,
	output logic   nempty
);

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full   = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign nempty = (cnt_q != '0);
	assign rdata  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/mjc_div.sv
module mjc_div import mjc_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  div_in_t  din,
	output div_out_t dout
);

	// restoring division, one quotient bit per stage
	logic [DEN_W-1:0]    r_q   [DIV_BITS];
	den_t                d_q   [DIV_BITS];
	logic [DIV_BITS-1:0] lo_q  [DIV_BITS+1];
	logic                ovf_q [DIV_BITS+1];
	logic                neg_q [DIV_BITS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_q[0] <= (din.num >= (num_t'(din.den) << DIV_BITS));
			r_q[0]   <= din.num[DIV_BITS +: DEN_W];
			lo_q[0]  <= din.num[DIV_BITS-1:0];
			d_q[0]   <= din.den;
			neg_q[0] <= din.neg;
		end
	end

	for (genvar k = 1; k <= DIV_BITS; k++) begin : g_stage
		logic [DEN_W:0] rr;
		logic           ge;

		assign rr = {r_q[k-1], lo_q[k-1][DIV_BITS-1]};
		assign ge = (rr >= {1'b0, d_q[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				lo_q[k]  <= {lo_q[k-1][DIV_BITS-2:0], ge};
				ovf_q[k] <= ovf_q[k-1];
				neg_q[k] <= neg_q[k-1];
			end
		end

		if (k < DIV_BITS) begin : g_rem
			logic [DEN_W:0] diff;
			assign diff = rr - {1'b0, d_q[k-1]};
			always_ff @(posedge clk) begin
				if (en) begin
					r_q[k] <= ge ? diff[DEN_W-1:0] : rr[DEN_W-1:0];
					d_q[k] <= d_q[k-1];
				end
			end
		end
	end

	assign dout.q   = lo_q[DIV_BITS];
	assign dout.ovf = ovf_q[DIV_BITS];
	assign dout.neg = neg_q[DIV_BITS];

endmodule

FILE: design/mjc_back.sv
module mjc_back import mjc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  logic   head_valid,
	output logic   pop,
	mjc_rsp_if.source rsp
);

	typedef struct packed {
		logic zero;
		in_t  p0;
		in_t  v0;
		in_t  a0;
	} side_t;

	typedef struct packed {
		coef_t v;
		logic  sat;
	} sat_t;

	typedef logic [IN_W+T_W-1:0] ulo_t;

	function automatic div_in_t setup(input n_t n, input t5_t den, input int sh);
		div_in_t r;
		mag_t    mag;
		mag   = n[N_W-1] ? mag_t'(-n) : mag_t'(n);
		r.num = (num_t'(mag) << (sh + 1)) + num_t'(den);
		r.den = den_t'(den) << 1;
		r.neg = n[N_W-1];
		return r;
	endfunction

	function automatic sat_t clamp(input div_out_t d);
		sat_t r;
		r.sat = 1'b0;
		r.v   = coef_t'(d.q);
		if (!d.neg) begin
			if (d.ovf || d.q[DIV_BITS-1]) begin
				r.v   = COEF_MAX;
				r.sat = 1'b1;
			end
		end else if (d.ovf || (d.q > {1'b1, {(DIV_BITS-1){1'b0}}})) begin
			r.v   = COEF_MIN;
			r.sat = 1'b1;
		end else begin
			r.v = -coef_t'(d.q);
		end
		return r;
	endfunction

	// signed 32-bit by T
	function automatic vt_t mul_s(input in_t x, input t_t t);
		return vt_t'(x) * vt_t'($signed({1'b0, t}));
	endfunction

	// unsigned 32-bit by T
	function automatic ulo_t mul_u(input logic [IN_W-1:0] x, input t_t t);
		return ulo_t'(x) * ulo_t'(t);
	endfunction

	function automatic t2_t mul_tt(input t_t a, input t_t b);
		return t2_t'(a) * t2_t'(b);
	endfunction

	logic adv;
	logic rsp_vld_q;

	assign adv = !rsp_vld_q || rsp.ready;
	assign pop = adv && head_valid;

	// s1
	vt_t  v0t_s1, a0t_s1;
	t2_t  t2_s1;
	dif_t dp_s1, dv_s1, b2_s1;
	t_t   t_s1;
	// s2: partial products
	vt_t  atth_s2;
	ulo_t attl_s2;
	b1_t  b1_s2;
	b2t_t b2t_s2;
	t2_t  t3h_s2, t3l_s2, t4a_s2, t4b_s2, t4c_s2;
	dif_t dp_s2;
	vt_t  v0t_s2;
	t_t   t_s2;
	// s3
	att_t att_s3;
	vt_t  b1th_s3, b2tth_s3;
	ulo_t b1tl_s3, b2ttl_s3;
	t3_t  t3_s3;
	t4_t  t4_s3;
	dif_t dp_s3;
	vt_t  v0t_s3;
	t_t   t_s3;
	// s4
	b0_t   b0_s4;
	b1t_t  b1t_s4;
	b2tt_t b2tt_s4;
	t2_t   t5p_s4 [T4_W/T_W];
	t4_t   t4_s4;
	t3_t   t3_s4;
	// s5
	n_t  n3_s5, n4_s5, n5_s5;
	t5_t t5_s5;
	t4_t t4_s5;
	t3_t t3_s5;
	// s6
	div_in_t ds3_s6, ds4_s6, ds5_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			v0t_s1 <= mul_s(head.v0, head.t);
			a0t_s1 <= mul_s(head.a0, head.t);
			t2_s1  <= mul_tt(head.t, head.t);
			dp_s1  <= head.dp;
			dv_s1  <= head.dv;
			b2_s1  <= head.b2;
			t_s1   <= head.t;

			atth_s2 <= mul_s(in_t'($signed(a0t_s1[VT_W-1:IN_W])), t_s1);
			attl_s2 <= mul_u(a0t_s1[IN_W-1:0], t_s1);
			b1_s2   <= (b1_t'(dv_s1) <<< IN_FRAC_BITS) - b1_t'(a0t_s1);
			b2t_s2  <= b2t_t'(b2_s1) * b2t_t'($signed({1'b0, t_s1}));
			t3h_s2  <= mul_tt(t2_s1[T2_W-1:T_W], t_s1);
			t3l_s2  <= mul_tt(t2_s1[T_W-1:0], t_s1);
			t4a_s2  <= mul_tt(t2_s1[T2_W-1:T_W], t2_s1[T2_W-1:T_W]);
			t4b_s2  <= mul_tt(t2_s1[T2_W-1:T_W], t2_s1[T_W-1:0]);
			t4c_s2  <= mul_tt(t2_s1[T_W-1:0], t2_s1[T_W-1:0]);
			dp_s2   <= dp_s1;
			v0t_s2  <= v0t_s1;
			t_s2    <= t_s1;

			att_s3   <= (att_t'(atth_s2) <<< IN_W) + att_t'(attl_s2);
			b1th_s3  <= mul_s(in_t'($signed(b1_s2[B1_W-1:IN_W])), t_s2);
			b1tl_s3  <= mul_u(b1_s2[IN_W-1:0], t_s2);
			b2tth_s3 <= mul_s(in_t'($signed(b2t_s2[B2T_W-1:IN_W])), t_s2);
			b2ttl_s3 <= mul_u(b2t_s2[IN_W-1:0], t_s2);
			t3_s3    <= (t3_t'(t3h_s2) << T_W) + t3_t'(t3l_s2);
			t4_s3    <= (t4_t'(t4a_s2) << T2_W) + (t4_t'(t4b_s2) << (T_W + 1))
				+ t4_t'(t4c_s2);
			dp_s3    <= dp_s2;
			v0t_s3   <= v0t_s2;
			t_s3     <= t_s2;

			b0_s4   <= (b0_t'(dp_s3) <<< (2 * IN_FRAC_BITS + 1))
				- (b0_t'(v0t_s3) <<< (IN_FRAC_BITS + 1)) - b0_t'(att_s3);
			b1t_s4  <= (b1t_t'(b1th_s3) <<< IN_W) + b1t_t'(b1tl_s3);
			b2tt_s4 <= (b2tt_t'(b2tth_s3) <<< IN_W) + b2tt_t'(b2ttl_s3);
			for (int j = 0; j < T4_W / T_W; j++) begin
				t5p_s4[j] <= mul_tt(t4_s3[j*T_W +: T_W], t_s3);
			end
			t4_s4 <= t4_s3;
			t3_s4 <= t3_s3;

			n3_s5 <= (n_t'(b0_s4) <<< 3) + (n_t'(b0_s4) <<< 1) - (n_t'(b1t_s4) <<< 3)
				+ n_t'(b2tt_s4);
			n4_s5 <= (n_t'(b1t_s4) <<< 4) - (n_t'(b1t_s4) <<< 1) - (n_t'(b0_s4) <<< 4)
				+ n_t'(b0_s4) - (n_t'(b2tt_s4) <<< 1);
			n5_s5 <= (n_t'(b0_s4) <<< 2) + (n_t'(b0_s4) <<< 1) - (n_t'(b1t_s4) <<< 2)
				- (n_t'(b1t_s4) <<< 1) + n_t'(b2tt_s4);
			t5_s5 <= (t5_t'(t5p_s4[3]) << (3 * T_W)) + (t5_t'(t5p_s4[2]) << (2 * T_W))
				+ (t5_t'(t5p_s4[1]) << T_W) + t5_t'(t5p_s4[0]);
			t4_s5 <= t4_s4;
			t3_s5 <= t3_s4;

			ds3_s6 <= setup(n3_s5, t5_t'(t3_s5), SH3);
			ds4_s6 <= setup(n4_s5, t5_t'(t4_s5), SH4);
			ds5_s6 <= setup(n5_s5, t5_s5, SH5);
		end
	end

	div_out_t q3, q4, q5;

	mjc_div u_div3 (.clk(clk), .en(adv), .din(ds3_s6), .dout(q3));
	mjc_div u_div4 (.clk(clk), .en(adv), .din(ds4_s6), .dout(q4));
	mjc_div u_div5 (.clk(clk), .en(adv), .din(ds5_s6), .dout(q5));

	side_t side_q [LAT];
	logic  vld_q  [LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= '{zero: head.zero, p0: head.p0, v0: head.v0, a0: head.a0};
			for (int i = 1; i < LAT; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= head_valid;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	sat_t  s3, s4, s5;
	side_t sd;

	assign s3 = clamp(q3);
	assign s4 = clamp(q4);
	assign s5 = clamp(q5);
	assign sd = side_q[LAT-1];

	coef_t      coef_q [6];
	logic [1:0] status_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sd.zero) begin
				for (int i = 0; i < 6; i++) begin
					coef_q[i] <= '0;
				end
				status_q <= ST_ZERO_T;
			end else begin
				coef_q[0] <= coef_t'(sd.p0) <<< (32 - IN_FRAC_BITS);
				coef_q[1] <= coef_t'(sd.v0) <<< (32 - IN_FRAC_BITS);
				coef_q[2] <= coef_t'(sd.a0) <<< (31 - IN_FRAC_BITS);
				coef_q[3] <= s3.v;
				coef_q[4] <= s4.v;
				coef_q[5] <= s5.v;
				status_q  <= (s3.sat || s4.sat || s5.sat) ? ST_SAT : ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= vld_q[LAT-1];
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.coef0  = coef_q[0];
	assign rsp.coef1  = coef_q[1];
	assign rsp.coef2  = coef_q[2];
	assign rsp.coef3  = coef_q[3];
	assign rsp.coef4  = coef_q[4];
	assign rsp.coef5  = coef_q[5];
	assign rsp.status = status_q;

endmodule

FILE: design/mjc_chk.sv
module mjc_chk import mjc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input coef_t      coef0,
	input coef_t      coef1,
	input coef_t      coef2,
	input coef_t      coef3,
	input coef_t      coef4,
	input coef_t      coef5,
	input logic [1:0] status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(coef3))
		else $error("rsp beat changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_ZERO_T |-> coef0 == '0 && coef1 == '0 && coef2 == '0
			&& coef3 == '0 && coef4 == '0 && coef5 == '0)
		else $error("zero duration with non-zero coefficients");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_SAT |-> coef3 == COEF_MAX || coef3 == COEF_MIN
			|| coef4 == COEF_MAX || coef4 == COEF_MIN
			|| coef5 == COEF_MAX || coef5 == COEF_MIN)
		else $error("saturation flagged without a clamped coefficient");

	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> coef0[31-IN_FRAC_BITS:0] == '0 && coef1[31-IN_FRAC_BITS:0] == '0)
		else $error("start state coefficients have stray fraction bits");

endmodule

bind min_jerk_coefficients_core mjc_chk u_mjc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.coef0     (rsp.coef0),
	.coef1     (rsp.coef1),
	.coef2     (rsp.coef2),
	.coef3     (rsp.coef3),
	.coef4     (rsp.coef4),
	.coef5     (rsp.coef5),
	.status    (rsp.status)
);
